>>> design/lzsc_pkg.sv
// Shared constants and types for the LZSS window compressor.
`timescale 1ns / 1ps
package lzsc_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int ADDR_W      = $clog2(WINDOW_SIZE);
	localparam int MAX_MATCH   = 18;
	localparam int CNT_W       = $clog2(MAX_MATCH + 1);
	localparam int DIST_W      = $clog2(WINDOW_SIZE + 1);
	localparam int GROUP_CMDS  = 8;
	localparam int GROUP_BYTES = 16;
	localparam int GIDX_W      = $clog2(GROUP_BYTES);
	localparam int FILL_W      = $clog2(GROUP_BYTES + 1);
	localparam int CMDS_W      = $clog2(GROUP_CMDS + 1);
	localparam int TOTAL_W     = 24;
	localparam int MIN_MATCH   = 3;

	localparam logic [ADDR_W-1:0]  RING_OFFSET = ADDR_W'(12'h012);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

	// control shared by every cell of the lookahead chain
	typedef struct packed {
		logic load;    // write the arriving byte into the selected cell
		logic shift;   // move every byte one cell toward the head
		logic clr_run; // drop all partial matches
		logic cmp_en;  // a history byte is present this cycle
	} cell_ctrl_t;

endpackage

>>> design/lzsc_ram.sv
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps
module lzsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/lzsc_cell.sv
// One lookahead cell: holds a byte and the partial-match flag for its offset.
`timescale 1ns / 1ps
module lzsc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lzsc_pkg::cell_ctrl_t ctrl,
	input  logic                load_sel,
	input  logic [7:0]          load_byte,
	input  logic [7:0]          next_byte,
	input  logic [7:0]          hist_byte,
	input  logic                run_in,
	input  logic                active,
	output logic [7:0]          byte_q,
	output logic                run_q,
	output logic                run_next
);
	import lzsc_pkg::*;

	// extend the neighbor's match by one byte when this cell agrees
	assign run_next = run_in & active & (hist_byte == byte_q);

	// hold, load or advance the lookahead byte
	always_ff @(posedge clk) begin
		if (ctrl.load && load_sel) begin
			byte_q <= load_byte;
		end else if (ctrl.shift) begin
			byte_q <= next_byte;
		end
	end

	// partial-match flag handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (ctrl.clr_run) begin
			run_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			run_q <= run_next;
		end
	end

endmodule

>>> design/lzss_window_compressor.sv
// Top level of the LZSS window compressor: control, history ring and cell chain.
//
//  channel | dir | tdata                        | tlast
//  s_axis  | in  | [7:0] in_byte                | in_last
//  m_axis  | out | [7:0] out_byte, [31:8] total | out_last
//
// A byte that does not complete the lookahead is taken without leaving idle.
// A command scans the whole written window once: one history byte per cycle from
// the RAM read port, then writes each consumed byte into the history ring.
// A group flush emits the flag byte, then the group bytes, as m_axis takes them.
// Reset clears all control; history contents need no clearing.
// s_axis is ready only between commands; a stalled m_axis holds the block.
`timescale 1ns / 1ps
module lzss_window_compressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] out_byte, [31:8] out_total
	output logic        m_axis_tlast
);
	import lzsc_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SETUP   = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_DECIDE  = 3'd3;
	localparam logic [2:0] ST_CONSUME = 3'd4;
	localparam logic [2:0] ST_POST    = 3'd5;
	localparam logic [2:0] ST_FLAG    = 3'd6;
	localparam logic [2:0] ST_BYTES   = 3'd7;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cap_q;
	logic [CNT_W-1:0]   best_q;
	logic [CNT_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  start_q;
	logic [DIST_W-1:0]  maxd_q;
	logic [DIST_W-1:0]  scan_q;
	logic               wfull_q;
	logic               lastmode_q;
	logic [7:0]         flags_q;
	logic [CMDS_W-1:0]  cmds_q;
	logic [FILL_W-1:0]  fill_q;
	logic [GIDX_W-1:0]  emit_q;
	logic [7:0]         gbytes_q [GROUP_BYTES];
	logic [TOTAL_W-1:0] total_q;
	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic [TOTAL_W-1:0] out_total_q;

	cell_ctrl_t         ctrl;
	logic [7:0]         cell_byte [MAX_MATCH];
	logic [MAX_MATCH-1:0] run_q;
	logic [MAX_MATCH-1:0] run_next;
	logic [7:0]         hist_byte;
	logic               ram_we;
	logic [ADDR_W-1:0]  rd_addr;

	logic               in_acc;
	logic               out_free;
	logic               hit_any;
	logic [CNT_W-1:0]   hit_k;
	logic [CNT_W-1:0]   hit_len;
	logic               final_flush;
	logic [ADDR_W-1:0]  ring_t;
	logic [TOTAL_W-1:0] total_inc;
	logic               emit_end;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign final_flush   = lastmode_q && (count_q == '0);
	assign ring_t        = start_q - RING_OFFSET;
	assign total_inc     = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;
	assign emit_end      = ({1'b0, emit_q} == fill_q - 1'b1);
	assign rd_addr       = base_q + scan_q[ADDR_W-1:0];
	assign ram_we        = (state_q == ST_CONSUME);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_total_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;

	// chain control
	always_comb begin
		ctrl.load    = in_acc;
		ctrl.shift   = (state_q == ST_CONSUME);
		ctrl.clr_run = (state_q == ST_SETUP);
		ctrl.cmp_en  = (state_q == ST_SCAN) && valid_s1;
	end

	// history ring
	lzsc_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_hist (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(pos_q),
		.wr_data(cell_byte[0]),
		.rd_addr(rd_addr),
		.rd_data(hist_byte)
	);

	// lookahead cells
	for (genvar k = 0; k < MAX_MATCH; k++) begin : g_cell
		lzsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load_sel (count_q == CNT_W'(k)),
			.load_byte(s_axis_tdata),
			.next_byte(cell_byte[(k + 1 < MAX_MATCH) ? k + 1 : k]),
			.hist_byte(hist_byte),
			.run_in   ((k == 0) ? 1'b1 : run_q[(k == 0) ? 0 : k - 1]),
			.active   (CNT_W'(k) < cap_q),
			.byte_q   (cell_byte[k]),
			.run_q    (run_q[k]),
			.run_next (run_next[k])
		);
	end

	// longest match ending at this history byte
	always_comb begin
		hit_any = 1'b0;
		hit_k   = '0;
		for (int k = 0; k < MAX_MATCH; k++) begin
			if (run_next[k]) begin
				hit_any = 1'b1;
				hit_k   = CNT_W'(k);
			end
		end
		hit_len = hit_k + 1'b1;
	end

	// group byte buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			if (best_q >= CNT_W'(MIN_MATCH)) begin
				gbytes_q[fill_q[GIDX_W-1:0]]        <= ring_t[7:0];
				gbytes_q[fill_q[GIDX_W-1:0] + 1'b1] <=
					{ring_t[ADDR_W-1:8], 4'(best_q - CNT_W'(MIN_MATCH))};
			end else begin
				gbytes_q[fill_q[GIDX_W-1:0]] <= cell_byte[0];
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (state_q == ST_SCAN && valid_s1 && hit_any && hit_len >= CNT_W'(MIN_MATCH)
			&& hit_len >= best_q) begin
			start_q <= addr_s1 - ADDR_W'(hit_k);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= '0;
			best_q      <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			base_q      <= '0;
			maxd_q      <= '0;
			scan_q      <= '0;
			wfull_q     <= 1'b0;
			lastmode_q  <= 1'b0;
			flags_q     <= '0;
			cmds_q      <= '0;
			fill_q      <= '0;
			emit_q      <= '0;
			total_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_total_q <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= count_q + 1'b1;
						if (s_axis_tlast) begin
							lastmode_q <= 1'b1;
							state_q    <= ST_SETUP;
						end else if (count_q + 1'b1 == CNT_W'(MAX_MATCH)) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					cap_q   <= lastmode_q ? count_q - 1'b1 : CNT_W'(MAX_MATCH);
					best_q  <= CNT_W'(MIN_MATCH - 1);
					maxd_q  <= wfull_q ? DIST_W'(WINDOW_SIZE) : {1'b0, pos_q};
					base_q  <= wfull_q ? pos_q : '0;
					scan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q < maxd_q) begin
						valid_s1 <= 1'b1;
						scan_q   <= scan_q + 1'b1;
					end else if (!valid_s1) begin
						state_q <= ST_DECIDE;
					end
					if (valid_s1 && hit_any && hit_len >= CNT_W'(MIN_MATCH)
						&& hit_len >= best_q) begin
						best_q <= hit_len;
					end
				end
				ST_DECIDE: begin
					if (best_q >= CNT_W'(MIN_MATCH)) begin
						rem_q  <= best_q;
						fill_q <= fill_q + FILL_W'(2);
					end else begin
						rem_q   <= CNT_W'(1);
						fill_q  <= fill_q + 1'b1;
						flags_q <= flags_q | (8'd1 << cmds_q);
					end
					cmds_q  <= cmds_q + 1'b1;
					state_q <= ST_CONSUME;
				end
				ST_CONSUME: begin
					pos_q   <= pos_q + 1'b1;
					count_q <= count_q - 1'b1;
					rem_q   <= rem_q - 1'b1;
					if (pos_q == {ADDR_W{1'b1}}) begin
						wfull_q <= 1'b1;
					end
					if (rem_q == CNT_W'(1)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (cmds_q == CMDS_W'(GROUP_CMDS)) begin
						state_q <= ST_FLAG;
					end else if (lastmode_q) begin
						state_q <= (count_q != '0) ? ST_SETUP : ST_FLAG;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLAG: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= flags_q;
						out_last_q  <= 1'b0;
						out_total_q <= '0;
						total_q     <= total_inc;
						emit_q      <= '0;
						state_q     <= ST_BYTES;
					end
				end
				ST_BYTES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= gbytes_q[emit_q];
						out_last_q  <= final_flush && emit_end;
						out_total_q <= (final_flush && emit_end) ? total_inc : '0;
						total_q     <= total_inc;
						emit_q      <= emit_q + 1'b1;
						if (emit_end) begin
							flags_q <= '0;
							cmds_q  <= '0;
							fill_q  <= '0;
							if (final_flush) begin
								pos_q      <= '0;
								wfull_q    <= 1'b0;
								total_q    <= '0;
								lastmode_q <= 1'b0;
								state_q    <= ST_IDLE;
							end else if (lastmode_q) begin
								state_q <= ST_SETUP;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/lzsc_checker.sv
// Port-level checks for the LZSS window compressor, bound to the top level.
`timescale 1ns / 1ps
module lzsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	import lzsc_pkg::*;

	// a stalled output beat holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// the closing beat carries a nonzero byte count
	a_total_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[31:8] != '0)
		else $error("closing beat without count");

	// other beats carry no count
	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:8] == '0)
		else $error("count on a non-closing beat");

	// the final input byte starts the drain, so input stops next cycle
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after a final byte");

endmodule

bind lzss_window_compressor lzsc_checker u_lzsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

>>> tb/tb.sv
// Self-checking testbench for the LZSS window compressor.
`timescale 1ns / 1ps

typedef struct {
	logic [7:0]  code_byte;
	logic        code_last;
	logic [23:0] code_total;
} lz_code_t;

class lz_scoreboard;
	logic [7:0]  ring [4096];
	logic [7:0]  ahead [18];
	int unsigned ahead_cnt, pos, wrapped, cmd_cnt;
	logic [7:0]  grp_bytes [16];
	logic [7:0]  grp_flags;
	int unsigned block_total;
	lz_code_t    pending [$];
	lz_code_t    step_codes [$];
	int          errors;

	function new();
		ahead_cnt = 0; pos = 0; wrapped = 0; cmd_cnt = 0;
		grp_flags = 0; block_total = 0; errors = 0;
	endfunction

	function void emit(logic [7:0] b);
		lz_code_t c;
		c.code_byte = b; c.code_last = 0; c.code_total = 0;
		step_codes.push_back(c);
		if (block_total < 24'hFFFFFF) block_total++;
	endfunction

	function int unsigned fill_of();
		int unsigned lits;
		lits = 0;
		for (int i = 0; i < cmd_cnt; i++) lits += grp_flags[i];
		return 2 * cmd_cnt - lits;
	endfunction

	function void flush_group();
		int unsigned f;
		if (cmd_cnt == 0) return;
		f = fill_of();
		emit(grp_flags);
		for (int i = 0; i < f && i < 16; i++) emit(grp_bytes[i]);
		grp_flags = 0;
		cmd_cnt = 0;
	endfunction

	function void retire(int unsigned n);
		if (n > ahead_cnt) n = ahead_cnt;
		for (int i = 0; i < n; i++) begin
			ring[pos] = ahead[i];
			pos = (pos + 1) % 4096;
			if (pos == 0) wrapped = 1;
		end
		for (int i = 0; i + n < ahead_cnt; i++) ahead[i] = ahead[i + n];
		ahead_cnt -= n;
	endfunction

	// greedy longest, nearest match, then code it into the group
	function void code_command(int unsigned cap);
		int unsigned best, best_d, max_d, lim, k, base, f;
		logic [11:0] t;
		if (ahead_cnt == 0) return;
		if (cap > ahead_cnt) cap = ahead_cnt;
		best = 2; best_d = 0;
		max_d = wrapped ? 4096 : pos;
		for (int unsigned d = 3; d <= max_d; d++) begin
			lim = cap < d ? cap : d;
			if (lim <= best) continue;
			base = (pos + 4096 - d) % 4096;
			k = 0;
			while (k < lim && ring[(base + k) % 4096] == ahead[k]) k++;
			if (k > best) begin
				best = k; best_d = d;
			end
		end
		f = fill_of();
		if (best >= 3 && f + 2 <= 16) begin
			t = 12'((pos + 4096 - best_d - 12'h012) % 4096);
			grp_bytes[f] = t[7:0];
			grp_bytes[f + 1] = {t[11:8], 4'(best - 3)};
			retire(best);
		end else begin
			if (f < 16) grp_bytes[f] = ahead[0];
			grp_flags[cmd_cnt] = 1'b1;
			retire(1);
		end
		cmd_cnt++;
		if (cmd_cnt >= 8) flush_group();
	endfunction

	// note one accepted raw byte and queue the codes it causes
	function void note_byte(logic [7:0] b, logic is_last);
		step_codes.delete();
		if (ahead_cnt < 18) begin
			ahead[ahead_cnt] = b;
			ahead_cnt++;
		end
		if (!is_last) begin
			if (ahead_cnt >= 18) code_command(18);
		end else begin
			while (ahead_cnt > 0) code_command(ahead_cnt - 1);
			flush_group();
			if (step_codes.size() > 0) begin
				step_codes[$].code_last = 1;
				step_codes[$].code_total = block_total;
			end
			pos = 0; wrapped = 0; block_total = 0; grp_flags = 0; cmd_cnt = 0;
		end
		foreach (step_codes[i]) pending.push_back(step_codes[i]);
	endfunction

	task report(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task check_code(logic [31:0] data, logic is_last);
		lz_code_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected beat data=%h last=%b", data, is_last));
			return;
		end
		e = pending.pop_front();
		if (data[7:0] !== e.code_byte)
			report($sformatf("byte %h, want %h", data[7:0], e.code_byte));
		if (is_last !== e.code_last)
			report($sformatf("last %b, want %b", is_last, e.code_last));
		if (data[31:8] !== e.code_total)
			report($sformatf("total %0d, want %0d", data[31:8], e.code_total));
	endtask
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 40000;

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [31:0] m_axis_tdata;

	lz_scoreboard sb = new();
	int  bytes_sent;
	bit  no_idle, hold_sink, sink_held;
	int  quiet_cycles;
	logic [7:0] block_buf [$];

	lzss_window_compressor DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0; m_axis_tready = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// note accepted input, check accepted output, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) sb.check_code(m_axis_tdata, m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("lzss_window_compressor regression: fail");
				$finish;
			end
		end
	end
	initial quiet_cycles = 0;

	// sink: random stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_sink && !sink_held) begin
				sink_held = 1;
				m_axis_tready <= 0;
				repeat (600) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_axis_tready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_byte(logic [7:0] b, logic is_last);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
		if (bytes_sent > 420) no_idle = 1;
	endtask

	task automatic send_block();
		foreach (block_buf[i]) send_byte(block_buf[i], i == block_buf.size() - 1);
		block_buf.delete();
	endtask

	// build a block of random literals and copies of earlier stretches
	task automatic make_block(int n, int alphabet);
		int seg, src;
		while (block_buf.size() < n) begin
			if (block_buf.size() > 3 && $urandom_range(0, 2) != 0) begin
				src = $urandom_range(0, block_buf.size() - 1);
				seg = $urandom_range(3, 20);
				for (int i = 0; i < seg && block_buf.size() < n; i++)
					block_buf.push_back(block_buf[src + i]);
			end else if (alphabet == 0) begin
				block_buf.push_back(8'($urandom));
			end else begin
				block_buf.push_back(8'($urandom_range(0, alphabet)));
			end
		end
	endtask

	initial begin
		bytes_sent = 0; no_idle = 0; hold_sink = 0; sink_held = 0;
		@(posedge arst_n);
		@(posedge clk);
		// one-byte block, two-byte block
		block_buf = '{8'h00}; send_block();
		block_buf = '{8'hFF, 8'hFF}; send_block();
		// long runs of one value: longest matches and the remaining-minus-one cap
		repeat (22) block_buf.push_back(8'h00);
		send_block();
		repeat (24) block_buf.push_back(8'hFF);
		send_block();
		// fill the sink during the long hold-off
		hold_sink = 1;
		make_block(60, 3); send_block();
		// random part: mostly small blocks, a few larger ones
		while (bytes_sent < 470) begin
			case ($urandom_range(0, 9))
				0: make_block($urandom_range(100, 200), 0);
				1, 2: make_block($urandom_range(1, 8), 0);
				3, 4: make_block($urandom_range(5, 50), 1);
				default: make_block($urandom_range(5, 50), 0);
			endcase
			// trim the block so the run ends near the planned byte count
			while (block_buf.size() > 470 - bytes_sent) void'(block_buf.pop_back());
			send_block();
		end
		s_axis_tvalid <= 0;
		s_axis_tlast  <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("lzss_window_compressor regression: pass");
		else
			$display("lzss_window_compressor regression: fail");
		$finish;
	end
endmodule
